[rtl/core/dmxtx_pkg.sv]
// ----------------------------------------------------------------------------
// dmxtx_pkg
// Shared codes, types and constants of the DMX512 frame transmitter.
// ----------------------------------------------------------------------------
package dmxtx_pkg;

  // Command codes carried on the func field of an input word
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_WRITE  = 3'd1;
  localparam logic [2:0] FUNC_COMMIT = 3'd2;
  localparam logic [2:0] FUNC_PAUSE  = 3'd3;
  localparam logic [2:0] FUNC_RESUME = 3'd4;
  localparam logic [2:0] FUNC_CLEAR  = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAB_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_TICKS = 3'd4;
  localparam int unsigned CFG_DATA_W = 24;

  // Configuration reset values
  localparam logic [7:0]  BIT_TICKS_RST     = 8'd4;
  localparam logic [15:0] BREAK_TICKS_RST   = 16'd115;
  localparam logic [15:0] MAB_TICKS_RST     = 16'd7;
  localparam logic [15:0] GAP_TICKS_RST     = 16'd44;
  localparam logic [23:0] REFRESH_TICKS_RST = 24'd1000000;

  // Serial byte framing: start bit, eight data bits, two stop bits
  localparam logic [10:0] SHIFT_IDLE = 11'h7FF;
  localparam logic [3:0]  FRAME_BITS = 4'd11;

  // Line phase as shown on tx_phase
  typedef enum logic [2:0] {
    PH_STOP  = 3'd0,
    PH_GAP   = 3'd1,
    PH_BREAK = 3'd2,
    PH_MAB   = 3'd3,
    PH_DATA  = 3'd4,
    PH_FULL  = 3'd5,
    PH_PAUSE = 3'd6
  } phase_e;

  // One result word
  typedef struct packed {
    logic       tx_line;
    logic [2:0] tx_phase;
    logic [9:0] slot_position;
    logic       frame_done;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic step;    // an input word is taken this cycle
    logic clr_we;  // clearing pass writes zero at the clear address
  } cmd_t;

endpackage

[rtl/core/dmxtx_ctrl.sv]
// ----------------------------------------------------------------------------
// dmxtx_ctrl
// Sequencer: runs the store clearing pass and gates the input channel.
// ----------------------------------------------------------------------------
module dmxtx_ctrl #(
  parameter int unsigned MAX_SLOTS = 512,
  parameter int unsigned AW        = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [2:0]          func_i,
  input  logic                buf_full_i,
  output logic                in_stall_o,
  output dmxtx_pkg::cmd_t     cmd_o,
  output logic [AW-1:0]       clr_addr_o
);
  import dmxtx_pkg::*;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

  state_e        state_q;
  logic [AW-1:0] clr_addr_q;
  logic          accept;

  // Stall while clearing or when the result buffer is full
  assign in_stall_o   = (state_q != ST_RUN) || buf_full_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign cmd_o.step   = accept;
  assign cmd_o.clr_we = (state_q == ST_CLEAR);
  assign clr_addr_o   = clr_addr_q;

  // Sweep the store after reset and after a clear word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_addr_q == LAST_ADDR) begin
            state_q    <= ST_RUN;
            clr_addr_q <= '0;
          end else begin
            clr_addr_q <= clr_addr_q + 1'b1;
          end
        end
        ST_RUN: begin
          if (accept && func_i == FUNC_CLEAR) begin
            state_q    <= ST_CLEAR;
            clr_addr_q <= '0;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

[rtl/core/dmxtx_datapath.sv]
// ----------------------------------------------------------------------------
// dmxtx_datapath
// Frame state, serial shifter, refresh timer, slot store and config registers.
// ----------------------------------------------------------------------------
module dmxtx_datapath #(
  parameter int unsigned MAX_SLOTS = 512,
  parameter int unsigned AW        = 9,
  parameter int unsigned CW        = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dmxtx_pkg::cmd_t                       cmd_i,
  input  logic [AW-1:0]                         clr_addr_i,
  input  logic [2:0]                            func_i,
  input  logic [8:0]                            slot_index_i,
  input  logic [7:0]                            slot_value_i,
  input  logic [9:0]                            channel_count_i,
  input  logic                                  cfg_we_i,
  input  logic [dmxtx_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dmxtx_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output dmxtx_pkg::res_t                       res_o
);
  import dmxtx_pkg::*;

  localparam logic [CW-1:0] SLOTS_CW  = CW'(MAX_SLOTS);
  localparam logic [9:0]    SLOTS_10  = 10'(MAX_SLOTS);

  // Configuration registers
  logic [7:0]  bit_ticks_q;
  logic [15:0] break_ticks_q, mab_ticks_q, gap_ticks_q;
  logic [23:0] refresh_ticks_q;

  // Frame state
  phase_e        phase_q, phase_d;
  logic [CW-1:0] slot_q, slot_d;
  logic [CW-1:0] active_q, active_d;
  logic [3:0]    bitc_q, bitc_d;
  logic [15:0]   tick_q, tick_d;
  logic [10:0]   shift_q, shift_d;
  logic [23:0]   refr_q, refr_d;

  // Slot store
  logic [7:0]    mem [MAX_SLOTS];
  logic [7:0]    rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [AW-1:0] rd_addr;

  // Serial byte step helpers
  logic [7:0]    bit1;
  logic [15:0]   brk1, mab1;
  logic [15:0]   tick_inc;
  logic [3:0]    bitc_inc;
  logic          busy_q, cb_fire, cb_fin;
  logic [15:0]   cb_tick;
  logic [10:0]   cb_shift;
  logic [3:0]    cb_bitc;
  logic [CW-1:0] limit, count_clamp;
  logic          done, go_gap, go_break, is_tick;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q     <= BIT_TICKS_RST;
      break_ticks_q   <= BREAK_TICKS_RST;
      mab_ticks_q     <= MAB_TICKS_RST;
      gap_ticks_q     <= GAP_TICKS_RST;
      refresh_ticks_q <= REFRESH_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BIT_TICKS:     bit_ticks_q     <= cfg_data_i[7:0];
        CFG_BREAK_TICKS:   break_ticks_q   <= cfg_data_i[15:0];
        CFG_MAB_TICKS:     mab_ticks_q     <= cfg_data_i[15:0];
        CFG_GAP_TICKS:     gap_ticks_q     <= cfg_data_i[15:0];
        CFG_REFRESH_TICKS: refresh_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero bit, break and mab settings act as one
  assign bit1 = (bit_ticks_q == '0) ? 8'd1 : bit_ticks_q;
  assign brk1 = (break_ticks_q == '0) ? 16'd1 : break_ticks_q;
  assign mab1 = (mab_ticks_q == '0) ? 16'd1 : mab_ticks_q;

  // One tick of the serial byte, from the registered state
  assign busy_q   = (shift_q != SHIFT_IDLE) || (bitc_q != '0);
  assign tick_inc = tick_q + 16'd1;
  assign bitc_inc = bitc_q + 4'd1;
  assign cb_fire  = tick_inc >= {8'd0, bit1};
  assign cb_fin   = cb_fire && (bitc_inc >= FRAME_BITS);
  assign cb_tick  = cb_fire ? 16'd0 : tick_inc;
  assign cb_shift = !cb_fire ? shift_q : (cb_fin ? SHIFT_IDLE : {1'b1, shift_q[10:1]});
  assign cb_bitc  = !cb_fire ? bitc_q : (cb_fin ? 4'd0 : bitc_inc);

  assign limit       = (phase_q == PH_FULL) ? SLOTS_CW : active_q;
  assign count_clamp = (channel_count_i > SLOTS_10) ? SLOTS_CW : channel_count_i[CW-1:0];

  // Next frame state for the word taken this cycle
  always_comb begin
    phase_d  = phase_q;
    slot_d   = slot_q;
    bitc_d   = bitc_q;
    tick_d   = tick_q;
    shift_d  = shift_q;
    refr_d   = refr_q;
    active_d = active_q;
    done     = 1'b0;
    go_gap   = 1'b0;
    go_break = 1'b0;
    is_tick  = 1'b0;
    if (cmd_i.step) begin
      unique case (func_i)
        FUNC_TICK: begin
          is_tick = 1'b1;
          if (refr_q != '1) begin
            refr_d = refr_q + 24'd1;
          end
          unique case (phase_q)
            PH_GAP: begin
              // finish a byte still in flight when the gap opened, then count the gap
              if (busy_q) begin
                tick_d  = cb_tick;
                shift_d = cb_shift;
                bitc_d  = cb_bitc;
                if (cb_fin && gap_ticks_q == '0) begin
                  go_break = 1'b1;
                end
              end else begin
                tick_d = tick_inc;
                if (tick_inc >= gap_ticks_q) begin
                  go_break = 1'b1;
                end
              end
            end
            PH_BREAK: begin
              tick_d = tick_inc;
              if (tick_inc >= brk1) begin
                phase_d = PH_MAB;
                tick_d  = '0;
              end
            end
            PH_MAB: begin
              tick_d = tick_inc;
              if (tick_inc >= mab1) begin
                phase_d = (bitc_q != '0) ? PH_FULL : PH_DATA;
                slot_d  = '0;
                shift_d = {2'b11, 8'd0, 1'b0};
                bitc_d  = '0;
                tick_d  = '0;
              end
            end
            PH_DATA, PH_FULL: begin
              tick_d  = cb_tick;
              shift_d = cb_shift;
              bitc_d  = cb_bitc;
              if (cb_fin) begin
                if (slot_q >= limit) begin
                  done   = 1'b1;
                  go_gap = 1'b1;
                end else begin
                  // next slot's level was prefetched from the store
                  slot_d  = slot_q + 1'b1;
                  shift_d = {2'b11, rd_q, 1'b0};
                  bitc_d  = '0;
                  tick_d  = '0;
                end
              end
            end
            PH_PAUSE: begin
              if (busy_q) begin
                tick_d  = cb_tick;
                shift_d = cb_shift;
                bitc_d  = cb_bitc;
              end
            end
            default: ;
          endcase
        end
        FUNC_COMMIT: begin
          active_d = count_clamp;
          if (phase_q == PH_STOP) begin
            go_gap = 1'b1;
          end
        end
        FUNC_PAUSE: begin
          if (phase_q != PH_STOP && phase_q != PH_PAUSE) begin
            if (phase_q == PH_BREAK || phase_q == PH_MAB) begin
              bitc_d  = '0;
              tick_d  = '0;
              shift_d = SHIFT_IDLE;
            end
            if (shift_d == SHIFT_IDLE && bitc_d == '0) begin
              tick_d = '0;
            end
            phase_d = PH_PAUSE;
          end
        end
        FUNC_RESUME: begin
          go_gap = 1'b1;
        end
        FUNC_CLEAR: begin
          active_d = '0;
        end
        default: ;
      endcase

      // Enter the gap: abandon break or mab, check for a zero-length gap
      if (go_gap) begin
        if (phase_d == PH_BREAK || phase_d == PH_MAB || phase_d == PH_STOP) begin
          bitc_d  = '0;
          tick_d  = '0;
          shift_d = SHIFT_IDLE;
        end
        phase_d = PH_GAP;
        if (shift_d == SHIFT_IDLE && bitc_d == '0) begin
          tick_d = '0;
          if (gap_ticks_q == '0) begin
            go_break = 1'b1;
          end
        end
      end

      // Start the break; bit counter flags a forced full frame
      if (go_break) begin
        phase_d = PH_BREAK;
        tick_d  = '0;
        slot_d  = '0;
        shift_d = SHIFT_IDLE;
        if (refr_d > refresh_ticks_q) begin
          refr_d = '0;
          bitc_d = 4'd1;
        end else begin
          bitc_d = '0;
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_STOP;
      slot_q   <= '0;
      active_q <= '0;
      bitc_q   <= '0;
      tick_q   <= '0;
      shift_q  <= SHIFT_IDLE;
      refr_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      slot_q   <= slot_d;
      active_q <= active_d;
      bitc_q   <= bitc_d;
      tick_q   <= tick_d;
      shift_q  <= shift_d;
      refr_q   <= refr_d;
    end
  end

  // Store port: clearing pass has the write port to itself
  assign mem_we  = cmd_i.clr_we ||
                   (cmd_i.step && func_i == FUNC_WRITE && 10'(slot_index_i) < SLOTS_10);
  assign mem_wa  = cmd_i.clr_we ? clr_addr_i : slot_index_i[AW-1:0];
  assign mem_wd  = cmd_i.clr_we ? 8'd0 : slot_value_i;
  assign rd_addr = (slot_d < SLOTS_CW) ? slot_d[AW-1:0] : '0;

  // Prefetch the level of the slot after the current one, forwarding a same-cycle write
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_we && mem_wa == rd_addr) begin
      rd_q <= mem_wd;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  // Tick words show the state before the update, others the state after it
  always_comb begin
    if (is_tick) begin
      res_o.tx_line       = (phase_q == PH_BREAK) ? 1'b0 : shift_q[0];
      res_o.tx_phase      = phase_q;
      res_o.slot_position = 10'(slot_q);
    end else begin
      res_o.tx_line       = (phase_d == PH_BREAK) ? 1'b0 : shift_d[0];
      res_o.tx_phase      = phase_d;
      res_o.slot_position = 10'(slot_d);
    end
    res_o.frame_done = done;
  end

endmodule

[rtl/core/dmxtx_outbuf.sv]
// ----------------------------------------------------------------------------
// dmxtx_outbuf
// Two-word result buffer between the datapath and the output channel.
// ----------------------------------------------------------------------------
module dmxtx_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dmxtx_pkg::res_t  res_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dmxtx_pkg::res_t  res_o
);
  import dmxtx_pkg::*;

  logic [1:0] count_q, count_d;
  res_t       head_q, tail_q;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign res_o       = head_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  // Hold the word count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Advance the payload: new words go to the free slot, pop shifts tail to head
  always_ff @(posedge clk_i) begin
    priority if (count_q == 2'd2) begin
      if (pop) begin
        head_q <= tail_q;
      end
    end else if (count_q == 2'd1) begin
      if (push_i && pop) begin
        head_q <= res_i;
      end else if (push_i) begin
        tail_q <= res_i;
      end
    end else begin
      if (push_i) begin
        head_q <= res_i;
      end
    end
  end

endmodule

[rtl/core/dmx512_frame_transmitter.sv]
// ----------------------------------------------------------------------------
// dmx512_frame_transmitter
// DMX512 line transmitter stepped by input words, one word per timebase tick.
//
// Input channel (in_valid_i / in_stall_o) takes a command word: tick, write
// slot, commit count, pause, resume or clear. Every taken word gives exactly
// one result word on the output channel (out_valid_o / out_stall_i) holding
// the line level, phase, slot position and end-of-frame flag.
// A taken word's result is registered in the result buffer; one word is
// taken per cycle while in_stall_o is low. A two-word result buffer lets the
// input go on while one result waits, so a stalled receiver holds off the
// input only once both buffer words are full.
// The slot store is a memory of MAX_SLOTS levels with one write port and one
// registered read port. After reset, and after each clear word, a clearing
// pass writes zero into it one entry a cycle, with in_stall_o held high.
// Configuration writes (cfg_valid_i / cfg_ready_o) are taken at any time,
// including during the clearing pass, and apply to the next tick.
// ----------------------------------------------------------------------------
module dmx512_frame_transmitter #(
  parameter int unsigned MAX_SLOTS = 512
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // command words
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [2:0]                            func_i,
  input  logic [8:0]                            slot_index_i,
  input  logic [7:0]                            slot_value_i,
  input  logic [9:0]                            channel_count_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  tx_line_o,
  output logic [2:0]                            tx_phase_o,
  output logic [9:0]                            slot_position_o,
  output logic                                  frame_done_o,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dmxtx_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dmxtx_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import dmxtx_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  cmd_t          cmd;
  logic [AW-1:0] clr_addr;
  logic          buf_full;
  res_t          res_new, res_out;

  assign cfg_ready_o = 1'b1;

  dmxtx_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .AW        (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .buf_full_i (buf_full),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .clr_addr_o (clr_addr)
  );

  dmxtx_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .AW        (AW),
    .CW        (CW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .clr_addr_i      (clr_addr),
    .func_i          (func_i),
    .slot_index_i    (slot_index_i),
    .slot_value_i    (slot_value_i),
    .channel_count_i (channel_count_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .res_o           (res_new)
  );

  dmxtx_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd.step),
    .res_i       (res_new),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign tx_line_o       = res_out.tx_line;
  assign tx_phase_o      = res_out.tx_phase;
  assign slot_position_o = res_out.slot_position;
  assign frame_done_o    = res_out.frame_done;

endmodule

[rtl/core/dmxtx_checker.sv]
// ----------------------------------------------------------------------------
// dmxtx_checker
// Port-level checks of the DMX512 frame transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module dmxtx_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  input  logic                                  tx_line_o,
  input  logic [2:0]                            tx_phase_o,
  input  logic [9:0]                            slot_position_o,
  input  logic                                  frame_done_o
);
  import dmxtx_pkg::*;

  // A stalled result word stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_line_o) &&
      $stable(tx_phase_o) && $stable(slot_position_o) && $stable(frame_done_o))
    else $error("result word changed while stalled");

  // The line is low throughout the break
  a_break_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_phase_o == PH_BREAK |-> !tx_line_o)
    else $error("line high during break");

  // End of frame comes only from a data phase, on a stop bit
  a_done_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |->
      (tx_phase_o == PH_DATA || tx_phase_o == PH_FULL) && tx_line_o)
    else $error("frame done outside a data stop bit");

  // Before the first commit the line idles at mark on slot zero
  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_phase_o == PH_STOP |-> tx_line_o && slot_position_o == 10'd0)
    else $error("stopped transmitter not idle");

endmodule

bind dmx512_frame_transmitter dmxtx_checker u_dmxtx_checker (.*);

[tb/dmx_line_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_line_check
// Watches the command, result and register channels of the DMX512 frame
// transmitter, keeps its own copy of the line state and compares each result
// word against the oldest predicted one.
// ----------------------------------------------------------------------------
module dmx_line_check
  import dmxtx_pkg::*;
#(
  parameter int unsigned SLOT_CAP = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [2:0]            func_i,
  input  logic [8:0]            slot_index_i,
  input  logic [7:0]            slot_value_i,
  input  logic [9:0]            channel_count_i,
  // result channel
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  tx_line_i,
  input  logic [2:0]            tx_phase_i,
  input  logic [9:0]            slot_position_i,
  input  logic                  frame_done_i,
  // register channel
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // verdict
  output int unsigned           fail_count_o,
  output int unsigned           outstanding_o
);

  localparam logic [23:0] TIMER_TOP = 24'hFFFFFF;
  localparam int unsigned PRINT_CAP = 100;

  // Register copies
  logic [7:0]  cfg_bit;
  logic [15:0] cfg_break;
  logic [15:0] cfg_mab;
  logic [15:0] cfg_gap;
  logic [23:0] cfg_refresh;

  // Line state copy
  logic [7:0]  lvl_mem [SLOT_CAP];
  logic [9:0]  live_count;
  phase_e      line_phase;
  logic [9:0]  slot_ctr;
  logic [3:0]  bit_ctr;
  logic [15:0] tick_ctr;
  logic [10:0] shifter;
  logic [23:0] refresh_ctr;

  res_t        line_due_q [$];
  res_t        got;
  res_t        want;
  int unsigned fails;

  assign fail_count_o = fails;

  task automatic report(string what);
    // keep the log short on a badly broken build
    if (fails < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
    fails++;
  endtask

  function automatic int unsigned floor1(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic byte_busy();
    return (shifter != SHIFT_IDLE) || (bit_ctr != 4'd0);
  endfunction

  function automatic void load_byte(logic [7:0] v);
    shifter  = {2'b11, v, 1'b0};
    bit_ctr  = '0;
    tick_ctr = '0;
  endfunction

  // Advance the serial byte by one tick; high when its last stop bit ends
  function automatic logic shift_tick();
    tick_ctr = tick_ctr + 16'd1;
    if (tick_ctr < floor1(cfg_bit)) return 1'b0;
    tick_ctr = '0;
    shifter  = {1'b1, shifter[10:1]};
    bit_ctr  = bit_ctr + 4'd1;
    if (bit_ctr >= FRAME_BITS) begin
      bit_ctr = '0;
      shifter = SHIFT_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Open a break; bit_ctr marks a forced full frame until data begins
  function automatic void start_break();
    line_phase = PH_BREAK;
    tick_ctr   = '0;
    slot_ctr   = '0;
    shifter    = SHIFT_IDLE;
    if (refresh_ctr > cfg_refresh) begin
      refresh_ctr = '0;
      bit_ctr     = 4'd1;
    end else begin
      bit_ctr = '0;
    end
  endfunction

  function automatic void gap_zero_check();
    if (!byte_busy() && cfg_gap == 16'd0) start_break();
  endfunction

  // Drop a break or mab in progress
  function automatic void drop_preamble();
    if (line_phase == PH_BREAK || line_phase == PH_MAB || line_phase == PH_STOP) begin
      bit_ctr  = '0;
      tick_ctr = '0;
      shifter  = SHIFT_IDLE;
    end
  endfunction

  function automatic void open_gap();
    drop_preamble();
    line_phase = PH_GAP;
    if (!byte_busy()) tick_ctr = '0;
    gap_zero_check();
  endfunction

  function automatic logic advance_tick();
    logic        done;
    int unsigned limit;
    done = 1'b0;
    if (refresh_ctr != TIMER_TOP) refresh_ctr = refresh_ctr + 24'd1;
    case (line_phase)
      PH_GAP: begin
        if (byte_busy()) begin
          if (shift_tick()) gap_zero_check();
        end else begin
          tick_ctr = tick_ctr + 16'd1;
          if (tick_ctr >= cfg_gap) start_break();
        end
      end
      PH_BREAK: begin
        tick_ctr = tick_ctr + 16'd1;
        if (tick_ctr >= floor1(cfg_break)) begin
          line_phase = PH_MAB;
          tick_ctr   = '0;
        end
      end
      PH_MAB: begin
        tick_ctr = tick_ctr + 16'd1;
        if (tick_ctr >= floor1(cfg_mab)) begin
          line_phase = (bit_ctr != 4'd0) ? PH_FULL : PH_DATA;
          slot_ctr   = '0;
          load_byte(8'h00);
        end
      end
      PH_DATA, PH_FULL: begin
        if (shift_tick()) begin
          limit = (line_phase == PH_FULL) ? SLOT_CAP : live_count;
          if (slot_ctr >= limit) begin
            done = 1'b1;
            open_gap();
          end else begin
            slot_ctr = slot_ctr + 10'd1;
            load_byte(lvl_mem[slot_ctr - 10'd1]);
          end
        end
      end
      PH_PAUSE: begin
        if (byte_busy()) void'(shift_tick());
      end
      default: ;
    endcase
    return done;
  endfunction

  // Work out the result word of one command word and update the state
  function automatic res_t predict_line(logic [2:0] f, logic [8:0] idx, logic [7:0] val,
                                        logic [9:0] cnt);
    res_t r;
    r.frame_done = 1'b0;
    if (f == FUNC_TICK) begin
      r.tx_line       = (line_phase == PH_BREAK) ? 1'b0 : shifter[0];
      r.tx_phase      = line_phase;
      r.slot_position = slot_ctr;
      r.frame_done    = advance_tick();
    end else begin
      case (f)
        FUNC_WRITE: begin
          if (idx < SLOT_CAP) lvl_mem[idx] = val;
        end
        FUNC_COMMIT: begin
          live_count = (cnt > SLOT_CAP) ? 10'(SLOT_CAP) : cnt;
          if (line_phase == PH_STOP) open_gap();
        end
        FUNC_PAUSE: begin
          if (line_phase != PH_STOP && line_phase != PH_PAUSE) begin
            drop_preamble();
            if (!byte_busy()) tick_ctr = '0;
            line_phase = PH_PAUSE;
          end
        end
        FUNC_RESUME: open_gap();
        FUNC_CLEAR: begin
          foreach (lvl_mem[i]) lvl_mem[i] = '0;
          live_count = '0;
        end
        default: ;
      endcase
      r.tx_line       = (line_phase == PH_BREAK) ? 1'b0 : shifter[0];
      r.tx_phase      = line_phase;
      r.slot_position = slot_ctr;
    end
    return r;
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_BIT_TICKS:     cfg_bit     = data[7:0];
      CFG_BREAK_TICKS:   cfg_break   = data[15:0];
      CFG_MAB_TICKS:     cfg_mab     = data[15:0];
      CFG_GAP_TICKS:     cfg_gap     = data[15:0];
      CFG_REFRESH_TICKS: cfg_refresh = data[23:0];
      default: ;
    endcase
  endfunction

  function automatic void reset_line();
    cfg_bit     = BIT_TICKS_RST;
    cfg_break   = BREAK_TICKS_RST;
    cfg_mab     = MAB_TICKS_RST;
    cfg_gap     = GAP_TICKS_RST;
    cfg_refresh = REFRESH_TICKS_RST;
    foreach (lvl_mem[i]) lvl_mem[i] = '0;
    live_count  = '0;
    line_phase  = PH_STOP;
    slot_ctr    = '0;
    bit_ctr     = '0;
    tick_ctr    = '0;
    shifter     = SHIFT_IDLE;
    refresh_ctr = '0;
  endfunction

  initial fails = 0;

  // Retire results first, then queue the prediction of a word taken this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_line();
      line_due_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) set_reg(cfg_index_i, cfg_data_i);
      if (out_valid_i && !out_stall_i) begin
        got = '{tx_line: tx_line_i, tx_phase: tx_phase_i, slot_position: slot_position_i,
                frame_done: frame_done_i};
        if (line_due_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = line_due_q.pop_front();
          if (got.tx_line !== want.tx_line)
            report($sformatf("tx_line got %0b want %0b", got.tx_line, want.tx_line));
          if (got.tx_phase !== want.tx_phase)
            report($sformatf("tx_phase got %0d want %0d", got.tx_phase, want.tx_phase));
          if (got.slot_position !== want.slot_position)
            report($sformatf("slot_position got %0d want %0d",
                             got.slot_position, want.slot_position));
          if (got.frame_done !== want.frame_done)
            report($sformatf("frame_done got %0b want %0b", got.frame_done, want.frame_done));
        end
      end
      if (in_valid_i && !in_stall_i)
        line_due_q.push_back(predict_line(func_i, slot_index_i, slot_value_i,
                                          channel_count_i));
      outstanding_o <= line_due_q.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command and register words into the DMX512 frame transmitter under
// several timing settings, with random gaps and stalls on both channels, and
// reports the verdict of the line checker.
// ----------------------------------------------------------------------------
module testbench;
  import dmxtx_pkg::*;

  localparam int unsigned SLOT_CAP    = 512;
  localparam logic [2:0]  FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0]  FUNC_SPARE_HI = 3'd7;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned LIMIT_NS    = 20_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            func = FUNC_TICK;
  logic [8:0]            slot_index = '0;
  logic [7:0]            slot_value = '0;
  logic [9:0]            channel_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  tx_line;
  logic [2:0]            tx_phase;
  logic [9:0]            slot_position;
  logic                  frame_done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BIT_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  calm = 1'b0;
  logic                  hold_req = 1'b0;
  int unsigned           fail_count;
  int unsigned           outstanding;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dmx512_frame_transmitter #(
    .MAX_SLOTS(SLOT_CAP)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .slot_index_i   (slot_index),
    .slot_value_i   (slot_value),
    .channel_count_i(channel_count),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tx_line_o      (tx_line),
    .tx_phase_o     (tx_phase),
    .slot_position_o(slot_position),
    .frame_done_o   (frame_done),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  dmx_line_check #(
    .SLOT_CAP(SLOT_CAP)
  ) u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .func_i         (func),
    .slot_index_i   (slot_index),
    .slot_value_i   (slot_value),
    .channel_count_i(channel_count),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .tx_line_i      (tx_line),
    .tx_phase_i     (tx_phase),
    .slot_position_i(slot_position),
    .frame_done_i   (frame_done),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // Receiver: random stalls, a long hold-off on request, none while calm
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 25);
      end
    end
  end

  // Offer one command word and hold it until taken; valid stays high
  task automatic put_word(logic [2:0] f, logic [8:0] idx, logic [7:0] val, logic [9:0] cnt);
    in_valid      <= 1'b1;
    func          <= f;
    slot_index    <= idx;
    slot_value    <= val;
    channel_count <= cnt;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic rest(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic offer(logic [2:0] f, logic [8:0] idx, logic [7:0] val, logic [9:0] cnt);
    put_word(f, idx, val, cnt);
    if (!calm && $urandom_range(0, 99) < 25) rest($urandom_range(1, 3));
  endtask

  task automatic tick_run(int unsigned n);
    repeat (n) offer(FUNC_TICK, 9'($urandom), 8'($urandom), 10'($urandom));
  endtask

  // Mostly ticks so that frames run on; counts mostly small, a few clamped
  task automatic random_run(int unsigned n);
    int unsigned pick;
    logic [2:0]  f;
    logic [9:0]  cnt;
    repeat (n) begin
      pick = $urandom_range(0, 999);
      if (pick < 720)      f = FUNC_TICK;
      else if (pick < 840) f = FUNC_WRITE;
      else if (pick < 910) f = FUNC_COMMIT;
      else if (pick < 930) f = FUNC_PAUSE;
      else if (pick < 970) f = FUNC_RESUME;
      else if (pick < 980) f = FUNC_CLEAR;
      else if (pick < 990) f = FUNC_SPARE_LO;
      else                 f = FUNC_SPARE_HI;
      cnt = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 8)) : 10'($urandom);
      offer(f, 9'($urandom), 8'($urandom), cnt);
    end
  endtask

  // Stop sending and wait for every predicted word to come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [7:0] bits, logic [15:0] brk, logic [15:0] mab,
                           logic [15:0] gap, logic [23:0] refresh);
    write_reg(CFG_BIT_TICKS, CFG_DATA_W'(bits));
    write_reg(CFG_BREAK_TICKS, CFG_DATA_W'(brk));
    write_reg(CFG_MAB_TICKS, CFG_DATA_W'(mab));
    write_reg(CFG_GAP_TICKS, CFG_DATA_W'(gap));
    write_reg(CFG_REFRESH_TICKS, refresh);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Fast timing with no gap; directed corners
    configure(8'd1, 16'd2, 16'd2, 16'd0, 24'hFFFFFF);
    offer(FUNC_PAUSE, '0, '0, '0);
    offer(FUNC_SPARE_LO, '1, '1, '1);
    offer(FUNC_SPARE_HI, '0, '0, '0);
    offer(FUNC_WRITE, 9'd0, 8'hFF, '0);
    offer(FUNC_WRITE, 9'd511, 8'h00, '1);
    offer(FUNC_WRITE, 9'h155, 8'hAA, '0);
    offer(FUNC_WRITE, 9'h0AA, 8'h55, '0);
    offer(FUNC_COMMIT, '0, '0, 10'd1023);
    tick_run(3);
    offer(FUNC_PAUSE, '0, '0, '0);
    offer(FUNC_COMMIT, '0, '0, 10'd0);
    offer(FUNC_RESUME, '0, '0, '0);
    tick_run(6);
    offer(FUNC_PAUSE, '0, '0, '0);
    tick_run(2);
    offer(FUNC_RESUME, '0, '0, '0);
    offer(FUNC_COMMIT, '0, '0, 10'd1);
    offer(FUNC_CLEAR, '0, '0, '0);

    // Random traffic with a stretch free of gaps and stalls
    random_run(100);
    calm <= 1'b1;
    random_run(150);
    calm <= 1'b0;
    random_run(100);
    settle();

    // Mid timing with refresh; long receiver hold-off and a full drain
    configure(8'd3, 16'd1, 16'd1, 16'd5, 24'd400);
    random_run(150);
    hold_req <= 1'b1;
    tick_run(1);
    hold_req <= 1'b0;
    tick_run(30);
    random_run(70);
    settle();
    random_run(100);
    settle();

    // Upper extremes of every register
    configure(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    random_run(100);
    settle();

    // Refresh forced every frame: start a full frame of all slots and run it a while
    configure(8'd1, 16'd1, 16'd1, 16'd1, 24'd1);
    repeat (40) offer(FUNC_WRITE, 9'($urandom), 8'($urandom), 10'($urandom));
    offer(FUNC_COMMIT, '0, '0, 10'd3);
    calm <= 1'b1;
    tick_run(250);
    calm <= 1'b0;
    tick_run(150);
    settle();

    // Back to reset timing
    configure(BIT_TICKS_RST, BREAK_TICKS_RST, MAB_TICKS_RST, GAP_TICKS_RST,
              REFRESH_TICKS_RST);
    random_run(200);

    settle();
    calm <= 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
